@@ rtl/wpp_pkg.sv @@
`timescale 1ns / 1ps

package wpp_pkg;

   // Four-character ids as they read from a little-endian shift of the byte stream
   localparam logic [31:0] ID_RIFF = 32'h4646_4952;
   localparam logic [31:0] ID_WAVE = 32'h4556_4157;
   localparam logic [31:0] ID_FMT  = 32'h2074_6D66;
   localparam logic [31:0] ID_DATA = 32'h6174_6164;
   localparam logic [31:0] ID_LIST = 32'h5453_494C;
   localparam logic [31:0] ID_NONE = 32'h0000_0000;

   localparam logic [15:0] PCM_FORMAT_TAG = 16'h0001;

   localparam logic KIND_SAMPLE = 1'b0;
   localparam logic KIND_ERROR  = 1'b1;

   typedef enum logic [2:0] {
      ERR_NONE  = 3'd0,
      ERR_RIFF  = 3'd1,
      ERR_WAVE  = 3'd2,
      ERR_FMT   = 3'd3,
      ERR_PCM   = 3'd4,
      ERR_CHUNK = 3'd5,
      ERR_TRUNC = 3'd6
   } err_type;

   typedef enum logic [3:0] {
      OP_PASS,       // consume bytes, no check
      OP_CHK_ID,     // compare the word against the step's id
      OP_CHK_PCM,    // format type must be PCM
      OP_CAP_CH,     // capture channel count
      OP_CAP_BLK,    // capture block size, zero is an error
      OP_CHUNK,      // data or LIST, anything else is an error
      OP_LIST_SIZE,  // load the skip counter
      OP_DATA_SIZE,  // load the divider
      OP_SKIP,       // drop one payload byte
      OP_DIV,        // one divider iteration per cycle
      OP_MUL_LO,     // channels * quotient low half
      OP_MUL_HI,     // channels * quotient high half
      OP_SUM,        // combine partial products, saturate
      OP_SAMPLE,     // two bytes per sample
      OP_STOP        // accept and ignore
   } op_type;

   typedef enum logic [4:0] {
      ST_RIFF_ID,
      ST_RIFF_SIZE,
      ST_WAVE_ID,
      ST_FMT_ID,
      ST_FMT_SIZE,
      ST_FMT_TYPE,
      ST_CHANNELS,
      ST_RATE,
      ST_BYTE_RATE,
      ST_BLOCK,
      ST_BITS,
      ST_CHUNK_ID,
      ST_LIST_SIZE,
      ST_SKIP,
      ST_DATA_SIZE,
      ST_DIVIDE,
      ST_MUL_LO,
      ST_MUL_HI,
      ST_SUM,
      ST_SAMPLE,
      ST_DONE,
      ST_HALT
   } step_type;

   // One control word per step; the step's condition selects alt over nxt
   typedef struct packed {
      op_type      op;
      logic [1:0]  last_idx;
      err_type     err;
      logic [31:0] id;
      step_type    nxt;
      step_type    alt;
   } ucode_type;

   typedef struct packed {
      logic load;
      logic run;
   } div_ctl_type;

   function automatic ucode_type uc(input op_type op, input logic [1:0] last_idx,
                                    input err_type err, input logic [31:0] id,
                                    input step_type nxt, input step_type alt);
      ucode_type w;
      w.op       = op;
      w.last_idx = last_idx;
      w.err      = err;
      w.id       = id;
      w.nxt      = nxt;
      w.alt      = alt;
      return w;
   endfunction

   function automatic ucode_type ucode_rom(input step_type s);
      ucode_type w;
      unique case (s)
         ST_RIFF_ID:   w = uc(OP_CHK_ID, 2'd3, ERR_RIFF, ID_RIFF, ST_RIFF_SIZE, ST_HALT);
         ST_RIFF_SIZE: w = uc(OP_PASS, 2'd3, ERR_NONE, ID_NONE, ST_WAVE_ID, ST_HALT);
         ST_WAVE_ID:   w = uc(OP_CHK_ID, 2'd3, ERR_WAVE, ID_WAVE, ST_FMT_ID, ST_HALT);
         ST_FMT_ID:    w = uc(OP_CHK_ID, 2'd3, ERR_FMT, ID_FMT, ST_FMT_SIZE, ST_HALT);
         ST_FMT_SIZE:  w = uc(OP_PASS, 2'd3, ERR_NONE, ID_NONE, ST_FMT_TYPE, ST_HALT);
         ST_FMT_TYPE:  w = uc(OP_CHK_PCM, 2'd1, ERR_PCM, ID_NONE, ST_CHANNELS, ST_HALT);
         ST_CHANNELS:  w = uc(OP_CAP_CH, 2'd1, ERR_NONE, ID_NONE, ST_RATE, ST_HALT);
         ST_RATE:      w = uc(OP_PASS, 2'd3, ERR_NONE, ID_NONE, ST_BYTE_RATE, ST_HALT);
         ST_BYTE_RATE: w = uc(OP_PASS, 2'd3, ERR_NONE, ID_NONE, ST_BLOCK, ST_HALT);
         ST_BLOCK:     w = uc(OP_CAP_BLK, 2'd1, ERR_FMT, ID_NONE, ST_BITS, ST_HALT);
         ST_BITS:      w = uc(OP_PASS, 2'd1, ERR_NONE, ID_NONE, ST_CHUNK_ID, ST_HALT);
         ST_CHUNK_ID:  w = uc(OP_CHUNK, 2'd3, ERR_CHUNK, ID_DATA, ST_DATA_SIZE,
                              ST_LIST_SIZE);
         ST_LIST_SIZE: w = uc(OP_LIST_SIZE, 2'd3, ERR_NONE, ID_NONE, ST_SKIP,
                              ST_CHUNK_ID);
         ST_SKIP:      w = uc(OP_SKIP, 2'd0, ERR_NONE, ID_NONE, ST_SKIP, ST_CHUNK_ID);
         ST_DATA_SIZE: w = uc(OP_DATA_SIZE, 2'd3, ERR_NONE, ID_NONE, ST_DIVIDE, ST_HALT);
         ST_DIVIDE:    w = uc(OP_DIV, 2'd0, ERR_NONE, ID_NONE, ST_DIVIDE, ST_MUL_LO);
         ST_MUL_LO:    w = uc(OP_MUL_LO, 2'd0, ERR_NONE, ID_NONE, ST_MUL_HI, ST_HALT);
         ST_MUL_HI:    w = uc(OP_MUL_HI, 2'd0, ERR_NONE, ID_NONE, ST_SUM, ST_HALT);
         ST_SUM:       w = uc(OP_SUM, 2'd0, ERR_NONE, ID_NONE, ST_SAMPLE, ST_DONE);
         ST_SAMPLE:    w = uc(OP_SAMPLE, 2'd1, ERR_NONE, ID_NONE, ST_SAMPLE, ST_DONE);
         ST_DONE:      w = uc(OP_STOP, 2'd0, ERR_NONE, ID_NONE, ST_DONE, ST_DONE);
         ST_HALT:      w = uc(OP_STOP, 2'd0, ERR_NONE, ID_NONE, ST_HALT, ST_HALT);
         default:      w = uc(OP_STOP, 2'd0, ERR_NONE, ID_NONE, ST_HALT, ST_HALT);
      endcase
      return w;
   endfunction

endpackage

@@ rtl/wav_pcm16_stream_parser.sv @@
`timescale 1ns / 1ps

// WAV PCM16 stream parser. Takes a WAVE file one byte per req_ transfer (or an end-of-file
// marker) and returns int16 samples as Q1.15 values, the final one flagged, or a single
// error result after which the block ignores everything until reset. Header, fmt block and
// chunk headers run at one byte per cycle under a microcoded step sequencer; a LIST payload
// is skipped at one byte per cycle. After the data chunk size arrives the block takes no
// byte during the radix-2 divide of size by block size and the two-half multiply by the
// channel count. Samples then take two bytes each, one per cycle.
// A byte is taken only while the output register is empty or being drained that cycle.
module wav_pcm16_stream_parser (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [7:0]         req_data_byte,
   input  logic               req_end_of_file,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_kind,
   output logic signed [15:0] rsp_sample,
   output logic               rsp_last_sample,
   output logic [15:0]        rsp_channels,
   output logic [2:0]         rsp_error_code
);
   import wpp_pkg::*;

   step_type    step_ff, step_in;
   logic [1:0]  cnt_ff, cnt_in;
   ucode_type   ucw;

   logic [31:0] field_ff, field_in;
   logic [15:0] ch_ff, ch_in;
   logic [15:0] blk_ff, blk_in;
   logic [31:0] skip_ff, skip_in;
   logic [31:0] samples_ff, samples_in;
   logic [7:0]  low_ff, low_in;
   logic [31:0] prod_lo_ff, prod_lo_in;
   logic [31:0] prod_hi_ff, prod_hi_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic        rsp_kind_ff, rsp_kind_in;
   logic [15:0] rsp_sample_ff, rsp_sample_in;
   logic        rsp_last_ff, rsp_last_in;
   logic [15:0] rsp_channels_ff, rsp_channels_in;
   err_type     rsp_err_ff, rsp_err_in;

   logic        byte_op;
   logic        accept;
   logic        take;
   logic        step_last;
   logic [31:0] byte_word;
   logic        fail;
   logic        cond;
   logic        eof_hit;
   logic        error_hit;
   logic        sample_hit;
   logic [47:0] count_sum;
   logic [31:0] count_sat;

   div_ctl_type div_ctl;
   logic [31:0] quotient;
   logic        div_done;

   assign ucw = ucode_rom(step_ff);

   assign byte_op   = !((ucw.op == OP_DIV) || (ucw.op == OP_MUL_LO) ||
                        (ucw.op == OP_MUL_HI) || (ucw.op == OP_SUM));
   assign req_ready = byte_op && (!rsp_valid_ff || rsp_ready);
   assign accept    = req_valid && req_ready;
   assign take      = accept && !req_end_of_file && (ucw.op != OP_STOP);
   assign step_last = (cnt_ff == ucw.last_idx);
   assign byte_word = {req_data_byte, field_ff[31:8]};

   assign count_sum = {prod_hi_ff, 16'h0000} + {16'h0000, prod_lo_ff};
   assign count_sat = (count_sum[47:32] != 16'h0000) ? 32'hFFFF_FFFF : count_sum[31:0];

   always_comb begin
      fail = 1'b0;
      cond = 1'b0;
      unique case (ucw.op)
         OP_CHK_ID:    fail = (byte_word != ucw.id);
         OP_CHK_PCM:   fail = (byte_word[31:16] != PCM_FORMAT_TAG);
         OP_CAP_BLK:   fail = (byte_word[31:16] == 16'h0000);
         OP_CHUNK: begin
            fail = (byte_word != ID_DATA) && (byte_word != ID_LIST);
            cond = (byte_word == ID_LIST);
         end
         OP_LIST_SIZE: cond = (byte_word == 32'd0);
         OP_SKIP:      cond = (skip_ff == 32'd1);
         OP_SAMPLE:    cond = (samples_ff == 32'd1);
         OP_DIV:       cond = div_done;
         OP_SUM:       cond = (count_sat == 32'd0);
         default: begin
         end
      endcase
   end

   assign eof_hit    = accept && req_end_of_file && (ucw.op != OP_STOP);
   assign error_hit  = eof_hit || (take && step_last && fail);
   assign sample_hit = take && step_last && (ucw.op == OP_SAMPLE);

   // next step
   always_comb begin
      step_in = step_ff;
      cnt_in  = cnt_ff;
      if (error_hit) begin
         step_in = ST_HALT;
         cnt_in  = '0;
      end else if (take) begin
         if (step_last) begin
            step_in = cond ? ucw.alt : ucw.nxt;
            cnt_in  = '0;
         end else begin
            cnt_in = cnt_ff + 2'd1;
         end
      end else if (!byte_op) begin
         step_in = cond ? ucw.alt : ucw.nxt;
      end
   end

   // datapath and result register
   always_comb begin
      field_in   = field_ff;
      ch_in      = ch_ff;
      blk_in     = blk_ff;
      skip_in    = skip_ff;
      samples_in = samples_ff;
      low_in     = low_ff;
      prod_lo_in = prod_lo_ff;
      prod_hi_in = prod_hi_ff;

      if (take) begin
         field_in = byte_word;
      end
      if (take && step_last && (ucw.op == OP_CAP_CH)) begin
         ch_in = byte_word[31:16];
      end
      if (take && step_last && (ucw.op == OP_CAP_BLK)) begin
         blk_in = byte_word[31:16];
      end
      if (take && step_last && (ucw.op == OP_LIST_SIZE)) begin
         skip_in = byte_word;
      end else if (take && (ucw.op == OP_SKIP)) begin
         skip_in = skip_ff - 32'd1;
      end
      if (ucw.op == OP_SUM) begin
         samples_in = count_sat;
      end else if (sample_hit) begin
         samples_in = samples_ff - 32'd1;
      end
      if (take && (ucw.op == OP_SAMPLE) && !step_last) begin
         low_in = req_data_byte;
      end
      if (ucw.op == OP_MUL_LO) begin
         prod_lo_in = {16'h0000, ch_ff} * {16'h0000, quotient[15:0]};
      end
      if (ucw.op == OP_MUL_HI) begin
         prod_hi_in = {16'h0000, ch_ff} * {16'h0000, quotient[31:16]};
      end

      rsp_valid_in    = rsp_valid_ff && !rsp_ready;
      rsp_kind_in     = rsp_kind_ff;
      rsp_sample_in   = rsp_sample_ff;
      rsp_last_in     = rsp_last_ff;
      rsp_channels_in = rsp_channels_ff;
      rsp_err_in      = rsp_err_ff;
      if (error_hit) begin
         rsp_valid_in    = 1'b1;
         rsp_kind_in     = KIND_ERROR;
         rsp_sample_in   = '0;
         rsp_last_in     = 1'b0;
         rsp_channels_in = '0;
         rsp_err_in      = eof_hit ? ERR_TRUNC : ucw.err;
      end else if (sample_hit) begin
         rsp_valid_in    = 1'b1;
         rsp_kind_in     = KIND_SAMPLE;
         rsp_sample_in   = {req_data_byte, low_ff};
         rsp_last_in     = cond;
         rsp_channels_in = ch_ff;
         rsp_err_in      = ERR_NONE;
      end
   end

   always_comb begin
      div_ctl.load = take && step_last && (ucw.op == OP_DATA_SIZE);
      div_ctl.run  = (ucw.op == OP_DIV);
   end

   wpp_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .ctl      (div_ctl),
      .dividend (byte_word),
      .divisor  (blk_ff),
      .quotient (quotient),
      .done     (div_done)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= ST_RIFF_ID;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         step_ff      <= step_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      field_ff        <= field_in;
      ch_ff           <= ch_in;
      blk_ff          <= blk_in;
      skip_ff         <= skip_in;
      samples_ff      <= samples_in;
      low_ff          <= low_in;
      prod_lo_ff      <= prod_lo_in;
      prod_hi_ff      <= prod_hi_in;
      rsp_kind_ff     <= rsp_kind_in;
      rsp_sample_ff   <= rsp_sample_in;
      rsp_last_ff     <= rsp_last_in;
      rsp_channels_ff <= rsp_channels_in;
      rsp_err_ff      <= rsp_err_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_kind        = rsp_kind_ff;
   assign rsp_sample      = rsp_sample_ff;
   assign rsp_last_sample = rsp_last_ff;
   assign rsp_channels    = rsp_channels_ff;
   assign rsp_error_code  = rsp_err_ff;

endmodule

@@ rtl/wpp_divider.sv @@
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per run cycle.
module wpp_divider (
   input  logic                 clock,
   input  logic                 reset,
   input  wpp_pkg::div_ctl_type ctl,
   input  logic [31:0]          dividend,
   input  logic [15:0]          divisor,
   output logic [31:0]          quotient,
   output logic                 done
);
   import wpp_pkg::*;

   logic [31:0] q_ff, q_in;
   logic [15:0] rem_ff, rem_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic [16:0] trial;
   logic [16:0] diff;
   logic        ge;

   assign trial = {rem_ff, q_ff[31]};
   assign diff  = trial - {1'b0, divisor};
   assign ge    = trial >= {1'b0, divisor};

   always_comb begin
      q_in   = q_ff;
      rem_in = rem_ff;
      cnt_in = cnt_ff;
      if (ctl.load) begin
         q_in   = dividend;
         rem_in = '0;
         cnt_in = '0;
      end else if (ctl.run) begin
         q_in   = {q_ff[30:0], ge};
         // remainder stays below the divisor, so 16 bits hold it
         rem_in = ge ? diff[15:0] : trial[15:0];
         cnt_in = cnt_ff + 5'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      q_ff   <= q_in;
      rem_ff <= rem_in;
   end

   assign quotient = q_ff;
   assign done     = ctl.run && (cnt_ff == 5'd31);

endmodule

@@ rtl/wpp_checker.sv @@
`timescale 1ns / 1ps

module wpp_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_kind,
   input logic [15:0] rsp_sample,
   input logic        rsp_last_sample,
   input logic [15:0] rsp_channels,
   input logic [2:0]  rsp_error_code
);
   import wpp_pkg::*;

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_kind) &&
         $stable(rsp_sample) && $stable(rsp_last_sample) &&
         $stable(rsp_channels) && $stable(rsp_error_code))
      else $error("result changed while stalled");

   a_error_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == KIND_ERROR) |-> (rsp_sample == 16'h0000) &&
         !rsp_last_sample && (rsp_channels == 16'h0000) && (rsp_error_code != ERR_NONE))
      else $error("malformed error result");

   a_sample_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == KIND_SAMPLE) |-> (rsp_error_code == ERR_NONE))
      else $error("sample result carries an error code");

   // nothing follows an error
   a_halt_after_error: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && (rsp_kind == KIND_ERROR) |=> !rsp_valid)
      else $error("result after an error transfer");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result pending after reset");

endmodule

bind wav_pcm16_stream_parser wpp_checker u_wpp_checker (.*);
